// ===== hw/rtl/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfr_pkg: shared types, constants and arithmetic for the palette fade remap
// Transaction payloads, control bundles, FSM states and the per-channel
// blend and distance functions used by the blend and scan units.
// ----------------------------------------------------------------------------
package pfr_pkg;

    // Field widths
    localparam int CHAN_W     = 8;
    localparam int RGB_W      = 3 * CHAN_W;
    localparam int IDX_W      = 8;
    localparam int FRAC_SHIFT = 7;                  // fraction is in 1/128 units
    localparam int DIFF_W     = CHAN_W + 1;         // c - t, signed
    localparam int PROD_W     = 2 * DIFF_W;         // (c - t) * fraction, signed
    localparam int BLEND_W    = PROD_W - FRAC_SHIFT; // blended channel, signed
    localparam int SQ_W       = 20;                 // one squared channel difference
    localparam int DIST_W     = SQ_W + 1;           // sum of three squares

    // Parameter defaults
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int REMAP_FIRST_DEF     = 240;
    localparam int REMAP_END_DEF       = 255;

    // Action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Configuration register indexes
    localparam int  CFG_IDX_W         = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_INDEX  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_FRACTION = 1'b1;

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  entry_index;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] queried_index;
        logic [IDX_W-1:0] mapped_index;
    } out_item_t;

    typedef struct packed {
        logic signed [BLEND_W-1:0] r;
        logic signed [BLEND_W-1:0] g;
        logic signed [BLEND_W-1:0] b;
    } blend_rgb_t;

    typedef struct packed {
        logic tgt_load;   // read data holds the target colour
        logic mul_load;   // read data holds the source colour
    } blend_ctrl_t;

    typedef struct packed {
        logic             clear;      // start of a lookup
        logic [IDX_W-1:0] clear_idx;  // answer when no candidate exists
        logic             issue;      // candidate read issued this cycle
        logic [IDX_W-1:0] issue_idx;
    } scan_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] best_idx;
    } scan_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_TGT,
        ST_RD_SRC,
        ST_MUL,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    // Extract channel k (0 red, 1 green, 2 blue) of a packed colour
    function automatic logic [CHAN_W-1:0] rgb_chan(logic [RGB_W-1:0] rgb, int k);
        return rgb[CHAN_W*(2-k) +: CHAN_W];
    endfunction

    // (c - t) * fraction
    function automatic logic signed [PROD_W-1:0] fade_product(
        logic [CHAN_W-1:0] c, logic [CHAN_W-1:0] t, logic [CHAN_W-1:0] frac);
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] fs;
        diff = $signed({1'b0, c}) - $signed({1'b0, t});
        fs   = $signed({1'b0, frac});
        return diff * fs;
    endfunction

    // c - product / 128, division truncated toward zero
    function automatic logic signed [BLEND_W-1:0] fade_channel(
        logic [CHAN_W-1:0] c, logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0]  rounded;
        logic signed [PROD_W-1:0]  shifted;
        logic signed [BLEND_W-1:0] quot;
        rounded = prod[PROD_W-1] ? prod + PROD_W'((1 << FRAC_SHIFT) - 1) : prod;
        shifted = rounded >>> FRAC_SHIFT;
        quot    = shifted[BLEND_W-1:0];
        return $signed({{(BLEND_W-CHAN_W){1'b0}}, c}) - quot;
    endfunction

    // (p - blended)^2
    function automatic logic [SQ_W-1:0] dist_sq(
        logic [CHAN_W-1:0] p, logic signed [BLEND_W-1:0] bl);
        logic signed [BLEND_W-1:0]   d;
        logic signed [2*BLEND_W-1:0] sq;
        d  = $signed({{(BLEND_W-CHAN_W){1'b0}}, p}) - bl;
        sq = d * d;
        return sq[SQ_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/pfr_ram.sv =====
// ----------------------------------------------------------------------------
// pfr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pfr_ram #(
    parameter  int WIDTH  = 24,
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pfr_blend.sv =====
// ----------------------------------------------------------------------------
// pfr_blend: fade blend of the source colour toward the target colour
// Captures target and source from the palette read port, registers the three
// channel products, then registers the blended, signed colour.
// ----------------------------------------------------------------------------
module pfr_blend
    import pfr_pkg::*;
(
    input  logic              clk,
    input  blend_ctrl_t       ctrl,
    input  logic [RGB_W-1:0]  rd_data,
    input  logic [CHAN_W-1:0] fraction,
    output blend_rgb_t        blended
);

    logic [RGB_W-1:0]         tgt_reg;
    logic [RGB_W-1:0]         src_reg;
    logic signed [PROD_W-1:0] prod_r_reg;
    logic signed [PROD_W-1:0] prod_g_reg;
    logic signed [PROD_W-1:0] prod_b_reg;
    blend_rgb_t               blend_reg;
    blend_rgb_t               blend_next;

    // Hold the target colour
    always_ff @(posedge clk)
    begin
        if (ctrl.tgt_load)
        begin
            tgt_reg <= rd_data;
        end
    end

    // Register source colour and channel products
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_load)
        begin
            src_reg    <= rd_data;
            prod_r_reg <= fade_product(rgb_chan(rd_data, 0), rgb_chan(tgt_reg, 0), fraction);
            prod_g_reg <= fade_product(rgb_chan(rd_data, 1), rgb_chan(tgt_reg, 1), fraction);
            prod_b_reg <= fade_product(rgb_chan(rd_data, 2), rgb_chan(tgt_reg, 2), fraction);
        end
    end

    // Scale the products and subtract from the source channels
    always_comb
    begin
        blend_next.r = fade_channel(rgb_chan(src_reg, 0), prod_r_reg);
        blend_next.g = fade_channel(rgb_chan(src_reg, 1), prod_g_reg);
        blend_next.b = fade_channel(rgb_chan(src_reg, 2), prod_b_reg);
    end

    always_ff @(posedge clk)
    begin
        blend_reg <= blend_next;
    end

    assign blended = blend_reg;

endmodule

// ===== hw/rtl/pfr_scan.sv =====
// ----------------------------------------------------------------------------
// pfr_scan: nearest-colour search over the remap candidates
// Three-stage pipeline behind the palette read port: read data, squared
// channel differences, then sum and compare against the best so far.
// ----------------------------------------------------------------------------
module pfr_scan
    import pfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctrl_t       ctrl,
    input  logic [RGB_W-1:0] rd_data,
    input  blend_rgb_t       blended,
    output scan_status_t     status
);

    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              sq_valid_reg;
    logic [IDX_W-1:0]  sq_idx_reg;
    logic [SQ_W-1:0]   sq_r_reg;
    logic [SQ_W-1:0]   sq_g_reg;
    logic [SQ_W-1:0]   sq_b_reg;
    logic              found_reg;
    logic [DIST_W-1:0] best_d_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [DIST_W-1:0] dist_sum;
    logic              take;

    // Track which read data belongs to a candidate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= ctrl.issue;
            sq_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= ctrl.issue_idx;
        sq_idx_reg <= rd_idx_reg;
    end

    // Square the channel differences
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            sq_r_reg <= dist_sq(rgb_chan(rd_data, 0), blended.r);
            sq_g_reg <= dist_sq(rgb_chan(rd_data, 1), blended.g);
            sq_b_reg <= dist_sq(rgb_chan(rd_data, 2), blended.b);
        end
    end

    // Sum and compare; strict less-than keeps the lowest index on ties
    always_comb
    begin
        dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
        take     = sq_valid_reg && (!found_reg || (dist_sum < best_d_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            best_idx_reg <= ctrl.clear_idx;
        end
        else if (take)
        begin
            best_d_reg   <= dist_sum;
            best_idx_reg <= sq_idx_reg;
        end
    end

    assign status.busy     = rd_valid_reg | sq_valid_reg;
    assign status.best_idx = best_idx_reg;

endmodule

// ===== hw/rtl/palette_fade_remap_lookup.sv =====
// ----------------------------------------------------------------------------
// palette_fade_remap_lookup: palette store with fade-table nearest-colour lookup
// Palette writes are accepted only while no lookup is in progress. A lookup of
// index 0 or of an index at or above REMAP_FIRST returns that index with no search;
// any other lookup reads the target and source colours, blends them, then scans
// the N = REMAP_END - REMAP_FIRST candidates (15 for the defaults) one after another
// through the single read port of the palette memory; a held result waits on out_stall.
// Reset clears control state and the config registers; the palette is not
// cleared and holds nothing defined until written.
// ----------------------------------------------------------------------------
module palette_fade_remap_lookup
    import pfr_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int REMAP_FIRST     = REMAP_FIRST_DEF,
    parameter int REMAP_END       = REMAP_END_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAN_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] FIRST_CAND = IDX_W'(REMAP_FIRST);
    localparam logic [IDX_W-1:0] LAST_CAND  = IDX_W'(REMAP_END - 1);
    localparam logic SCAN_EMPTY = (REMAP_END <= REMAP_FIRST);

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  cand_reg;
    logic [IDX_W-1:0]  cand_next;
    logic [IDX_W-1:0]  query_reg;
    logic              direct_reg;
    logic [IDX_W-1:0]  direct_map_reg;
    logic [IDX_W-1:0]  target_reg;
    logic [CHAN_W-1:0] fraction_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic              in_accept;
    logic              accept_lookup;
    logic              lookup_direct;
    logic              out_free;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [RGB_W-1:0]  ram_rdata;
    blend_ctrl_t       blend_ctrl;
    blend_rgb_t        blended;
    scan_ctrl_t        scan_ctrl;
    scan_status_t      scan_status;

    assign in_accept     = in_valid && !in_stall;
    assign accept_lookup = in_accept && (in_data.action == ACT_LOOKUP);
    assign ram_we        = in_accept && (in_data.action == ACT_WRITE);
    assign lookup_direct = (in_data.entry_index == '0) ||
                           (in_data.entry_index >= FIRST_CAND);
    assign out_free      = !out_valid_reg || !out_stall;
    assign in_stall      = (state_reg != ST_IDLE);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            fraction_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_INDEX:  target_reg   <= cfg_data;
                CFG_FADE_FRACTION: fraction_reg <= cfg_data;
            endcase
        end
    end

    // Palette memory
    pfr_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(in_data.entry_index)),
        .wdata ({in_data.red_in, in_data.green_in, in_data.blue_in}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pfr_blend u_blend (
        .clk      (clk),
        .ctrl     (blend_ctrl),
        .rd_data  (ram_rdata),
        .fraction (fraction_reg),
        .blended  (blended)
    );

    pfr_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (scan_ctrl),
        .rd_data (ram_rdata),
        .blended (blended),
        .status  (scan_status)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cand_next  = cand_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_lookup)
                begin
                    state_next = lookup_direct ? ST_RESULT : ST_RD_TGT;
                end
            end
            ST_RD_TGT: state_next = ST_RD_SRC;
            ST_RD_SRC: state_next = ST_MUL;
            ST_MUL:
            begin
                cand_next  = FIRST_CAND;
                state_next = SCAN_EMPTY ? ST_DRAIN : ST_SCAN;
            end
            ST_SCAN:
            begin
                cand_next = cand_reg + 1'b1;
                if (cand_reg == LAST_CAND)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!scan_status.busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs: read address and unit controls
    always_comb
    begin
        ram_raddr           = ADDR_W'(cand_reg);
        blend_ctrl.tgt_load = 1'b0;
        blend_ctrl.mul_load = 1'b0;
        scan_ctrl.clear     = accept_lookup;
        scan_ctrl.clear_idx = target_reg;
        scan_ctrl.issue     = 1'b0;
        scan_ctrl.issue_idx = cand_reg;
        unique case (state_reg)
            ST_RD_TGT: ram_raddr = ADDR_W'(target_reg);
            ST_RD_SRC:
            begin
                ram_raddr           = ADDR_W'(query_reg);
                blend_ctrl.tgt_load = 1'b1;
            end
            ST_MUL:    blend_ctrl.mul_load = 1'b1;
            ST_SCAN:   scan_ctrl.issue = 1'b1;
            ST_IDLE, ST_DRAIN, ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the query and its candidate counter
    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        if (accept_lookup)
        begin
            query_reg      <= in_data.entry_index;
            direct_reg     <= lookup_direct;
            direct_map_reg <= in_data.entry_index;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_RESULT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RESULT && out_free)
        begin
            out_data_reg.queried_index <= query_reg;
            out_data_reg.mapped_index  <= direct_reg ? direct_map_reg : scan_status.best_idx;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_result_from_result_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_RESULT)
    ) else $error("result presented outside the result state");

    a_scan_idle_at_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept |-> !scan_status.busy
    ) else $error("transaction accepted while the candidate pipeline is busy");

    a_no_write_during_lookup: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DRAIN) |-> !ram_we
    ) else $error("palette written while a lookup is reading it");

endmodule

// ===== dv/palette_fade_remap_lookup_tb.sv =====
// ----------------------------------------------------------------------------
// palette_fade_remap_lookup_tb: self-checking bench for the palette fade lookup
// Fills the palette, then runs fade lookups under several target/fraction
// settings. A behavioural predictor tracks the palette and the registers and
// checks every lookup result in order. Sender bursts, receiver stalls and one
// long output hold-off exercise the flow control.
// ----------------------------------------------------------------------------
module palette_fade_remap_lookup_tb;
    import pfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES = 40;     // beyond the longest lookup
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 345;
    localparam int MAX_REPORTS = 60;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CHAN_W-1:0]    cfg_data = '0;

    // Predictor state, updated on accepted transactions and register writes
    logic [RGB_W-1:0] palette_model [PALETTE_ENTRIES_DEF];
    logic [IDX_W-1:0] fade_target = '0;
    logic [CHAN_W-1:0] fade_amount = '0;
    out_item_t        fade_results [$];

    // Generator view: what the queued requests will have written
    logic [RGB_W-1:0] gen_palette [PALETTE_ENTRIES_DEF];
    bit               gen_written [PALETTE_ENTRIES_DEF];
    logic [IDX_W-1:0] gen_target = '0;
    in_item_t         request_queue [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  in_fired = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  stall_mode = 0;
    int  mode_left = 0;
    int  burst_left = 1;
    int  gap_left = 0;

    palette_fade_remap_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // One channel blended toward the target, truncating toward zero
    function automatic int blend_chan(input logic [CHAN_W-1:0] c, input logic [CHAN_W-1:0] t,
                                      input int f);
        return int'(c) - ((int'(c) - int'(t)) * f) / 128;
    endfunction

    // Nearest candidate to the faded colour of one palette index
    function automatic logic [IDX_W-1:0] fade_lookup(input logic [IDX_W-1:0] idx);
        logic [RGB_W-1:0] src;
        logic [RGB_W-1:0] tgt;
        logic [RGB_W-1:0] cand;
        logic [IDX_W-1:0] best;
        int br, bg, bb, dr, dg, db, d, best_d;
        if (idx == 0)
            return '0;
        if (idx >= REMAP_FIRST_DEF)
            return idx;
        src = palette_model[idx];
        tgt = palette_model[fade_target];
        br = blend_chan(src[23:16], tgt[23:16], int'(fade_amount));
        bg = blend_chan(src[15:8], tgt[15:8], int'(fade_amount));
        bb = blend_chan(src[7:0], tgt[7:0], int'(fade_amount));
        best = fade_target;
        best_d = 32'h7fff_ffff;
        for (int k = REMAP_FIRST_DEF; k < REMAP_END_DEF; k++)
        begin
            cand = palette_model[k];
            dr = int'(cand[23:16]) - br;
            dg = int'(cand[15:8]) - bg;
            db = int'(cand[7:0]) - bb;
            d = dr * dr + dg * dg + db * db;
            if (d < best_d)
            begin
                best_d = d;
                best = IDX_W'(k);
                if (d == 0)
                    break;
            end
        end
        return best;
    endfunction

    // A lookup is legal only once every entry it reads has been written
    function automatic bit lookup_safe(input logic [IDX_W-1:0] idx);
        if (idx == 0 || idx >= REMAP_FIRST_DEF)
            return 1'b1;
        if (!gen_written[idx] || !gen_written[gen_target])
            return 1'b0;
        for (int k = REMAP_FIRST_DEF; k < REMAP_END_DEF; k++)
        begin
            if (!gen_written[k])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    task automatic queue_write(input logic [IDX_W-1:0] idx, input logic [RGB_W-1:0] rgb);
        in_item_t it;
        it.action = ACT_WRITE;
        it.entry_index = idx;
        {it.red_in, it.green_in, it.blue_in} = rgb;
        gen_written[idx] = 1'b1;
        gen_palette[idx] = rgb;
        request_queue.push_back(it);
    endtask

    task automatic queue_lookup(input logic [IDX_W-1:0] idx);
        in_item_t it;
        it.action = ACT_LOOKUP;
        it.entry_index = idx;
        {it.red_in, it.green_in, it.blue_in} = RGB_W'($urandom);
        request_queue.push_back(it);
    endtask

    // Mostly lookups on a filled palette; writes keep candidates changing
    task automatic queue_random_item();
        logic [IDX_W-1:0] idx;
        logic [RGB_W-1:0] rgb;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
        begin
            idx = ($urandom_range(0, 9) < 3) ?
                  IDX_W'($urandom_range(REMAP_FIRST_DEF, REMAP_END_DEF - 1)) : IDX_W'($urandom);
            if ($urandom_range(0, 6) == 0)
                rgb = gen_palette[$urandom_range(REMAP_FIRST_DEF, REMAP_END_DEF - 1)];
            else
                rgb = {rand_chan(), rand_chan(), rand_chan()};
            queue_write(idx, rgb);
        end
        else
        begin
            roll = $urandom_range(0, 19);
            if (roll < 2)
                idx = '0;
            else if (roll < 5)
                idx = IDX_W'($urandom_range(REMAP_FIRST_DEF, 255));
            else
                idx = IDX_W'($urandom_range(1, REMAP_FIRST_DEF - 1));
            if (lookup_safe(idx))
                queue_lookup(idx);
            else
                queue_write(idx, {rand_chan(), rand_chan(), rand_chan()});
        end
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAN_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait for every transaction and result to clear, then let the block settle
    task automatic wait_idle();
        while (request_queue.size() != 0 || in_valid || fade_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [IDX_W-1:0] tgt, input logic [CHAN_W-1:0] frac,
                             input bit with_hold);
        set_reg(CFG_TARGET_INDEX, tgt);
        set_reg(CFG_FADE_FRACTION, frac);
        gen_target = tgt;
        for (int n = 0; n < PHASE_ITEMS; n++)
            queue_random_item();
        if (with_hold)
            hold_req = 1'b1;
        wait_idle();
    endtask

    function automatic logic [IDX_W-1:0] pick_written();
        logic [IDX_W-1:0] idx;
        idx = IDX_W'($urandom);
        while (!gen_written[idx])
            idx = IDX_W'($urandom);
        return idx;
    endfunction

    // Input side: model each accepted transaction; register writes
    always @(posedge clk)
    begin
        out_item_t res;
        if (rst_n && in_valid && !in_stall)
        begin
            in_fired = 1'b1;
            if (in_data.action == ACT_WRITE)
                palette_model[in_data.entry_index] =
                    {in_data.red_in, in_data.green_in, in_data.blue_in};
            else
            begin
                res.queried_index = in_data.entry_index;
                res.mapped_index = fade_lookup(in_data.entry_index);
                fade_results.push_back(res);
            end
        end
        if (rst_n && cfg_we)
        begin
            if (cfg_index == CFG_TARGET_INDEX)
                fade_target = cfg_data;
            else if (cfg_index == CFG_FADE_FRACTION)
                fade_amount = cfg_data;
        end
    end

    // Driver: bursts of requests with random gaps in between
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fired))
        begin
            in_fired = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (request_queue.size() > 0)
            begin
                in_data <= request_queue.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                               ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) :
                                                             $urandom_range(1, 5);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall pattern in modes, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (fade_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result queried_index=%0d mapped_index=%0d",
                             $realtime, out_data.queried_index, out_data.mapped_index);
            end
            else
            begin
                want = fade_results.pop_front();
                if (out_data.queried_index !== want.queried_index)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: queried_index expected %0d actual %0d", $realtime,
                                 want.queried_index, out_data.queried_index);
                end
                if (out_data.mapped_index !== want.mapped_index)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mapped_index for %0d expected %0d actual %0d",
                                 $realtime, want.queried_index, want.mapped_index,
                                 out_data.mapped_index);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("palette_fade_remap_lookup: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: candidates at colour extremes, a tie pair, exact matches
        queue_write(8'd240, 24'h000000);
        queue_write(8'd241, 24'hFFFFFF);
        queue_write(8'd242, 24'hFF0000);
        queue_write(8'd243, 24'h00FF00);
        queue_write(8'd244, 24'h0000FF);
        queue_write(8'd245, 24'h808080);
        queue_write(8'd246, 24'h808080);
        queue_write(8'd247, 24'hFF00FF);
        queue_write(8'd248, 24'h00FFFF);
        queue_write(8'd249, 24'hFFFF00);
        queue_write(8'd250, 24'h404040);
        queue_write(8'd251, 24'hC0C0C0);
        queue_write(8'd252, 24'h202020);
        queue_write(8'd253, 24'hE0E0E0);
        queue_write(8'd254, 24'h101010);
        queue_write(8'd255, 24'hFEDCBA);
        queue_write(8'd0, 24'h123456);
        queue_write(8'd1, 24'h808080);
        queue_write(8'd239, 24'hFFFFFF);
        queue_write(8'd128, 24'h7F7F81);
        queue_lookup(8'd0);
        queue_lookup(8'd1);
        queue_lookup(8'd239);
        queue_lookup(8'd128);
        queue_lookup(8'd240);
        queue_lookup(8'd254);
        queue_lookup(8'd255);
        wait_idle();

        // Random phases over several register settings
        run_phase(8'd254, 8'd128, 1'b0);
        run_phase(8'd255, 8'd255, 1'b0);
        run_phase(8'd0, 8'd1, 1'b0);
        run_phase(pick_written(), CHAN_W'($urandom), 1'b1);
        run_phase(pick_written(), 8'd0, 1'b0);

        if (mismatches == 0)
            $display("palette_fade_remap_lookup: match");
        else
            $display("palette_fade_remap_lookup: mismatch");
        $finish;
    end

endmodule
